[sv/pure_pursuit_steering_top_assert.svh]
// Assertion macros for the pure pursuit steering block
`ifndef PURE_PURSUIT_STEERING_TOP_ASSERT_SVH
`define PURE_PURSUIT_STEERING_TOP_ASSERT_SVH
// Assert that a condition implies a consequence in the same cycle.
`define PPS_ASSERT_IMP(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle.
`define PPS_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

[sv/pps_pkg.sv]
// Shared types and constants for the pure pursuit steering block
`default_nettype none
package pps_pkg;
    localparam int unsigned CordicSteps = 28;
    localparam logic signed [63:0] CordicGainQ30 = 64'sd652032874;
    localparam logic [31:0] TwoPiQ29 = 32'd3373259426;
    localparam logic signed [17:0] SteerLimit = 18'sd102944;
    localparam logic [22:0] LdReset = 23'd65536;
    localparam logic [19:0] WbReset = 20'd98304;
    localparam logic [19:0] LrReset = 20'd49152;

    typedef enum logic [1:0] {
        REG_LD = 2'd0,
        REG_WB = 2'd1,
        REG_LR = 2'd2,
        REG_TLEN = 2'd3
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ROT,
        ST_TRIG_FIX,
        ST_REAR_MX,
        ST_REAR_MY,
        ST_REAR_SUB,
        ST_SCAN_RD,
        ST_SCAN_WAIT,
        ST_SCAN_D,
        ST_SCAN_SQX,
        ST_SCAN_SQY,
        ST_SCAN_CMP,
        ST_SEL_RD,
        ST_SEL_WAIT,
        ST_SEL_D,
        ST_LAT_MC,
        ST_LAT_MS,
        ST_LAT_FIX,
        ST_STEER_SET,
        ST_STEER_M1,
        ST_STEER_NORM,
        ST_VEC,
        ST_CONV_M,
        ST_CONV_FIX,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic req_type;
        logic [9:0] point_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0] yaw;
    } in_word_t;

    typedef struct packed {
        logic signed [17:0] steer_cmd;
        logic signed [31:0] look_x;
        logic signed [31:0] look_y;
        logic track_valid;
        logic ratio_saturated;
    } out_word_t;

    function automatic logic [29:0] atan_entry(input logic [4:0] i);
        logic [29:0] r;
        begin
            unique case (i)
                5'd0: r = 30'd536870912;
                5'd1: r = 30'd316933406;
                5'd2: r = 30'd167458907;
                5'd3: r = 30'd85004756;
                5'd4: r = 30'd42667331;
                5'd5: r = 30'd21354465;
                5'd6: r = 30'd10679838;
                5'd7: r = 30'd5340245;
                5'd8: r = 30'd2670163;
                5'd9: r = 30'd1335087;
                5'd10: r = 30'd667544;
                5'd11: r = 30'd333772;
                5'd12: r = 30'd166886;
                5'd13: r = 30'd83443;
                5'd14: r = 30'd41722;
                5'd15: r = 30'd20861;
                5'd16: r = 30'd10430;
                5'd17: r = 30'd5215;
                5'd18: r = 30'd2608;
                5'd19: r = 30'd1304;
                5'd20: r = 30'd652;
                5'd21: r = 30'd326;
                5'd22: r = 30'd163;
                5'd23: r = 30'd81;
                5'd24: r = 30'd41;
                5'd25: r = 30'd20;
                5'd26: r = 30'd10;
                5'd27: r = 30'd5;
                default: r = 30'd0;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

[sv/pure_pursuit_steering_top.sv]
// Pure pursuit steering controller top level with track table and sequencer
//
// A load word (req_type 0) writes one track point into the on-chip table and
// finishes without a result. A control word (req_type 1) runs a small
// sequencer around one shared multiplier and one CORDIC add/shift stage:
// sine/cosine rotation, rear-axle math, then per scanned track point a table
// read, two squares and a compare, up to the first point beyond the
// look-ahead radius or the end of the track, then point selection, lateral
// error, normalization, vectoring and angle scaling. A short track skips
// straight to the steering part. The table read is registered, so the scan
// rate is set by the read latency plus the serial use of the one multiplier.
// s_ready is low while a control word is in progress and while its result
// word waits. No clearing pass is run.
`default_nettype none
module pure_pursuit_steering_top
    import pps_pkg::*;
#(
    parameter int unsigned TRACK_DEPTH = 1024
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic s_ready,
    input  wire in_word_t s_data,
    output logic m_valid,
    input  wire logic m_ready,
    output out_word_t m_data,
    input  wire logic psel,
    input  wire logic penable,
    input  wire logic pwrite,
    input  wire logic [3:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);
    localparam int unsigned AW = (TRACK_DEPTH > 1) ? $clog2(TRACK_DEPTH) : 1;
    localparam int unsigned NW = AW + 1;

    logic signed [31:0] mem_x [TRACK_DEPTH];
    logic signed [31:0] mem_y [TRACK_DEPTH];
    logic signed [31:0] rdx_reg, rdy_reg;

    logic [22:0] ld_reg;
    logic [19:0] wb_reg, lr_reg;
    logic [10:0] tlen_reg;

    state_t state_reg, state_next;
    in_word_t req_reg;
    logic [4:0] step_reg, step_next;
    logic [NW-1:0] idx_reg, idx_next;
    logic [NW-1:0] sel_reg, sel_next;
    logic [NW-1:0] n_reg, n_next;
    logic signed [63:0] cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic signed [63:0] cs_reg, cs_next, sn_reg, sn_next;
    logic signed [63:0] xr_reg, xr_next, yr_reg, yr_next;
    logic signed [63:0] dx_reg, dx_next, dy_reg, dy_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [31:0] lat_reg, lat_next, hx_reg, hx_next, hy_reg, hy_next;
    logic valid_reg, valid_next, sat_reg, sat_next;
    out_word_t out_reg, out_next;
    logic m_valid_reg, m_valid_next;
    logic rd_en;
    logic [AW-1:0] rd_addr;

    // shared multiplier: one signed 34x34 product per cycle, wide enough for
    // a look-ahead offset between any two 32-bit positions
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    logic signed [63:0] prod_reg;
    assign mul_p = mul_a * mul_b;

    // shared CORDIC stage
    logic signed [63:0] sh_x, sh_y;
    logic [29:0] at;
    assign sh_x = cx_reg >>> step_reg;
    assign sh_y = cy_reg >>> step_reg;
    assign at = atan_entry(step_reg);

    logic signed [63:0] ld_s;
    assign ld_s = (ld_reg == 23'd0) ? 64'sd1 : {41'd0, ld_reg};

    assign pready = 1'b1;
    assign s_ready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_data = out_reg;

    logic wr_en;
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ld_reg <= LdReset;
            wb_reg <= WbReset;
            lr_reg <= LrReset;
            tlen_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_LD: ld_reg <= pwdata[22:0];
                REG_WB: wb_reg <= pwdata[19:0];
                REG_LR: lr_reg <= pwdata[19:0];
                REG_TLEN: tlen_reg <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_LD: prdata = {9'd0, ld_reg};
            REG_WB: prdata = {12'd0, wb_reg};
            REG_LR: prdata = {12'd0, lr_reg};
            REG_TLEN: prdata = {21'd0, tlen_reg};
            default: prdata = '0;
        endcase
    end

    // track memory: written by load words, read by the sequencer
    logic load_fire;
    assign load_fire = s_valid && s_ready && !s_data.req_type
        && ({22'd0, s_data.point_index} < TRACK_DEPTH);
    always_ff @(posedge aclk) begin
        if (load_fire) begin
            mem_x[AW'(s_data.point_index)] <= s_data.pos_x;
            mem_y[AW'(s_data.point_index)] <= s_data.pos_y;
        end
        if (rd_en) begin
            rdx_reg <= mem_x[rd_addr];
            rdy_reg <= mem_y[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_p[63:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_valid_reg <= 1'b0;
            lat_reg <= '0;
            hx_reg <= '0;
            hy_reg <= '0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
            lat_reg <= lat_next;
            hx_reg <= hx_next;
            hy_reg <= hy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) req_reg <= s_data;
        step_reg <= step_next;
        idx_reg <= idx_next;
        sel_reg <= sel_next;
        n_reg <= n_next;
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        cz_reg <= cz_next;
        cs_reg <= cs_next;
        sn_reg <= sn_next;
        xr_reg <= xr_next;
        yr_reg <= yr_next;
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        acc_reg <= acc_next;
        valid_reg <= valid_next;
        sat_reg <= sat_next;
        out_reg <= out_next;
    end

    logic signed [63:0] tx, ty, rnd, mag_dx, mag_dy, mag_l, wb2;
    logic [NW-1:0] n_calc;
    always_comb begin
        state_next = state_reg;
        step_next = step_reg;
        idx_next = idx_reg;
        sel_next = sel_reg;
        n_next = n_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        cz_next = cz_reg;
        cs_next = cs_reg;
        sn_next = sn_reg;
        xr_next = xr_reg;
        yr_next = yr_reg;
        dx_next = dx_reg;
        dy_next = dy_reg;
        acc_next = acc_reg;
        lat_next = lat_reg;
        hx_next = hx_reg;
        hy_next = hy_reg;
        valid_next = valid_reg;
        sat_next = sat_reg;
        out_next = out_reg;
        m_valid_next = m_valid_reg;
        mul_a = '0;
        mul_b = '0;
        rd_en = 1'b0;
        rd_addr = idx_reg[AW-1:0];
        tx = '0;
        ty = '0;
        rnd = '0;
        mag_dx = (dx_reg < 0) ? -dx_reg : dx_reg;
        mag_dy = (dy_reg < 0) ? -dy_reg : dy_reg;
        mag_l = (lat_reg < 0) ? -64'(lat_reg) : 64'(lat_reg);
        wb2 = {43'd0, wb_reg, 1'b0};
        n_calc = ({21'd0, tlen_reg} > TRACK_DEPTH) ? NW'(TRACK_DEPTH)
            : NW'(tlen_reg);

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready && s_data.req_type) begin
                    n_next = n_calc;
                    valid_next = (n_calc >= NW'(2));
                    step_next = '0;
                    cx_next = CordicGainQ30;
                    cy_next = '0;
                    cz_next = {34'd0, s_data.yaw[13:0], 16'd0};
                    state_next = (n_calc >= NW'(2)) ? ST_ROT : ST_STEER_SET;
                end
            end
            ST_ROT: begin
                if (cz_reg >= 0) begin
                    cx_next = cx_reg - sh_y;
                    cy_next = cy_reg + sh_x;
                    cz_next = cz_reg - 64'(at);
                end else begin
                    cx_next = cx_reg + sh_y;
                    cy_next = cy_reg - sh_x;
                    cz_next = cz_reg + 64'(at);
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(CordicSteps - 1)) state_next = ST_TRIG_FIX;
            end
            ST_TRIG_FIX: begin
                tx = (cx_reg + 64'sd2) >>> 2;
                ty = (cy_reg + 64'sd2) >>> 2;
                unique case (req_reg.yaw[15:14])
                    2'd0: begin cs_next = tx; sn_next = ty; end
                    2'd1: begin cs_next = -ty; sn_next = tx; end
                    2'd2: begin cs_next = -tx; sn_next = -ty; end
                    default: begin cs_next = ty; sn_next = -tx; end
                endcase
                state_next = ST_REAR_MX;
            end
            ST_REAR_MX: begin
                mul_a = {14'd0, lr_reg};
                mul_b = cs_reg[33:0];
                state_next = ST_REAR_MY;
            end
            ST_REAR_MY: begin
                mul_a = {14'd0, lr_reg};
                mul_b = sn_reg[33:0];
                rnd = (prod_reg + (64'sd1 <<< 27)) >>> 28;
                xr_next = 64'(req_reg.pos_x) - rnd;
                state_next = ST_REAR_SUB;
            end
            ST_REAR_SUB: begin
                rnd = (prod_reg + (64'sd1 <<< 27)) >>> 28;
                yr_next = 64'(req_reg.pos_y) - rnd;
                idx_next = '0;
                sel_next = '0;
                state_next = ST_SCAN_RD;
            end
            ST_SCAN_RD: begin
                rd_en = 1'b1;
                state_next = ST_SCAN_WAIT;
            end
            ST_SCAN_WAIT: begin
                state_next = ST_SCAN_D;
            end
            ST_SCAN_D: begin
                dx_next = xr_reg - 64'(rdx_reg);
                dy_next = yr_reg - 64'(rdy_reg);
                state_next = ST_SCAN_SQX;
            end
            ST_SCAN_SQX: begin
                if (mag_dx > ld_s || mag_dy > ld_s) begin
                    state_next = ST_SEL_RD;
                end else begin
                    mul_a = dx_reg[33:0];
                    mul_b = dx_reg[33:0];
                    state_next = ST_SCAN_SQY;
                end
            end
            ST_SCAN_SQY: begin
                mul_a = dy_reg[33:0];
                mul_b = dy_reg[33:0];
                acc_next = prod_reg;
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                mul_a = ld_s[33:0];
                mul_b = ld_s[33:0];
                acc_next = acc_reg + prod_reg;
                state_next = ST_SEL_D;
                step_next = 5'd1;
            end
            ST_SEL_D: begin
                // scan: compare against Ld squared from the registered product; select: take the read point
                if (step_reg == 5'd1) begin
                    if (acc_reg > prod_reg) begin
                        state_next = ST_SEL_RD;
                    end else begin
                        sel_next = idx_reg;
                        idx_next = idx_reg + NW'(1);
                        state_next = (idx_reg + NW'(1) >= n_reg) ? ST_SEL_RD
                            : ST_SCAN_RD;
                    end
                end else begin
                    hx_next = rdx_reg;
                    hy_next = rdy_reg;
                    dx_next = 64'(rdx_reg) - xr_reg;
                    dy_next = 64'(rdy_reg) - yr_reg;
                    state_next = ST_LAT_MC;
                end
            end
            ST_SEL_RD: begin
                rd_en = 1'b1;
                rd_addr = sel_reg[AW-1:0];
                step_next = '0;
                state_next = ST_SEL_WAIT;
            end
            ST_SEL_WAIT: begin
                state_next = ST_SEL_D;
            end
            ST_LAT_MC: begin
                mul_a = cs_reg[33:0];
                mul_b = dy_reg[33:0];
                state_next = ST_LAT_MS;
            end
            ST_LAT_MS: begin
                mul_a = sn_reg[33:0];
                mul_b = dx_reg[33:0];
                acc_next = prod_reg;
                state_next = ST_LAT_FIX;
            end
            ST_LAT_FIX: begin
                rnd = (acc_reg - prod_reg + (64'sd1 <<< 27)) >>> 28;
                if (rnd > 64'sd2147483647) lat_next = 32'sh7fffffff;
                else if (rnd < -64'sd2147483648) lat_next = 32'sh80000000;
                else lat_next = rnd[31:0];
                state_next = ST_STEER_SET;
            end
            ST_STEER_SET: begin
                sat_next = mag_l > ld_s;
                if (mag_l > ld_s) begin
                    cx_next = ld_s;
                    cy_next = (lat_reg < 0) ? -wb2 : wb2;
                    state_next = ST_STEER_NORM;
                end else begin
                    mul_a = ld_s[33:0];
                    mul_b = ld_s[33:0];
                    state_next = ST_STEER_M1;
                end
                step_next = '0;
            end
            ST_STEER_M1: begin
                if (step_reg == 5'd0) begin
                    cx_next = prod_reg;
                    mul_a = wb2[33:0];
                    mul_b = 34'(lat_reg);
                    step_next = 5'd1;
                end else begin
                    cy_next = prod_reg;
                    state_next = ST_STEER_NORM;
                end
            end
            ST_STEER_NORM: begin
                tx = (cx_reg < 0) ? -cx_reg : cx_reg;
                ty = (cy_reg < 0) ? -cy_reg : cy_reg;
                if (tx < (64'sd1 <<< 52) && ty < (64'sd1 <<< 52)) begin
                    cx_next = cx_reg <<< 1;
                    cy_next = cy_reg <<< 1;
                end else begin
                    cz_next = '0;
                    step_next = '0;
                    state_next = ST_VEC;
                end
            end
            ST_VEC: begin
                if (cy_reg > 0) begin
                    cx_next = cx_reg + sh_y;
                    cy_next = cy_reg - sh_x;
                    cz_next = cz_reg + 64'(at);
                end else begin
                    cx_next = cx_reg - sh_y;
                    cy_next = cy_reg + sh_x;
                    cz_next = cz_reg - 64'(at);
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(CordicSteps - 1)) state_next = ST_CONV_M;
            end
            ST_CONV_M: begin
                mul_a = cz_reg[33:0];
                mul_b = {2'b0, TwoPiQ29};
                state_next = ST_CONV_FIX;
            end
            ST_CONV_FIX: begin
                rnd = (prod_reg + (64'sd1 <<< 44)) >>> 45;
                if (rnd > 64'(SteerLimit)) out_next.steer_cmd = SteerLimit;
                else if (rnd < -64'(SteerLimit))
                    out_next.steer_cmd = -SteerLimit;
                else out_next.steer_cmd = rnd[17:0];
                out_next.look_x = hx_reg;
                out_next.look_y = hy_reg;
                out_next.track_valid = valid_reg;
                out_next.ratio_saturated = sat_reg;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                m_valid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

[sv/pps_checker.sv]
// Port-level checker for the pure pursuit steering block
`default_nettype none
`include "pure_pursuit_steering_top_assert.svh"
module pps_checker
    import pps_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire out_word_t m_data,
    input wire logic pready
);
    logic out_stall;
    logic steer_in_range;
    assign out_stall = m_valid && !m_ready;
    assign steer_in_range = (m_data.steer_cmd <= SteerLimit)
        && (m_data.steer_cmd >= -SteerLimit);

    `PPS_ASSERT_IMP(a_no_take_while_full, aclk, aresetn, m_valid, !s_ready)
    `PPS_ASSERT_NEXT(a_hold_result, aclk, aresetn, out_stall, m_valid && $stable(m_data))
    `PPS_ASSERT_IMP(a_steer_range, aclk, aresetn, m_valid, steer_in_range)
    `PPS_ASSERT_IMP(a_pready, aclk, aresetn, 1'b1, pready)
endmodule
bind pure_pursuit_steering_top pps_checker u_pps_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data), .pready(pready)
);
`default_nettype wire
